@@ design/mvna_pkg.sv @@
// ----------------------------------------------------------------------------
// mvna_pkg
// Types, codes and widths shared by the vertex normal accumulator modules.
// ----------------------------------------------------------------------------
package mvna_pkg;

	localparam int VERTEX_DEPTH_DEF = 1024;
	localparam int INDEX_W          = 10;
	localparam int COORD_W          = 24;
	localparam int EDGE_W           = COORD_W + 1;
	localparam int PROD_W           = 2 * EDGE_W;
	localparam int CROSS_W          = PROD_W + 1;
	localparam int NORM_W           = 16;

	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_TRIANGLE = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;
	localparam logic [1:0] OP_CLEAR    = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]                operation;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [INDEX_W-1:0]        corner_a;
		logic [INDEX_W-1:0]        corner_b;
		logic [INDEX_W-1:0]        corner_c;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic                     normal_valid;
	} result_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vec_t;

	typedef struct packed {
		logic                      used;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} sum_ent_t;

	typedef struct packed {
		logic signed [CROSS_W-1:0] x;
		logic signed [CROSS_W-1:0] y;
		logic signed [CROSS_W-1:0] z;
	} cross_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] x;
		logic signed [NORM_W-1:0] y;
		logic signed [NORM_W-1:0] z;
	} nrm_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_VRD_A,
		ST_VRD_B,
		ST_VRD_C,
		ST_EDGE,
		ST_MUL,
		ST_TNORM,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_RD_SUM,
		ST_RD_CHK,
		ST_RNORM
	} state_t;

	typedef enum logic [2:0] {
		NS_IDLE,
		NS_SHIFT,
		NS_SQ,
		NS_SQRT,
		NS_DIV
	} nstate_t;

endpackage

@@ design/mvna_norm.sv @@
// ----------------------------------------------------------------------------
// mvna_norm
// Sequential Q2.14 normalizer: range shift, sum of squares, bit-pair integer
// square root and a restoring divide, one step per cycle.
// ----------------------------------------------------------------------------
module mvna_norm import mvna_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  cross_t vec,
	output logic   done,
	output nrm_t   nrm
);

	localparam int MAG_W  = CROSS_W;
	localparam int RED_W  = 30;
	localparam int SQ_W   = 2 * RED_W + 2;
	localparam int LEN_W  = 32;
	localparam int FRAC_W = 14;
	localparam int QUO_W  = FRAC_W + 1;
	localparam int REM_W  = LEN_W + FRAC_W;

	nstate_t state_q, state_d;

	logic [MAG_W-1:0]         m_q [3];
	logic [2:0]               neg_q;
	logic [1:0]               cnt_q;
	logic [2*RED_W-1:0]       prod_q;
	logic [SQ_W-1:0]          sq_q, root_q, bit_q;
	logic [LEN_W-1:0]         len_q;
	logic                     len_zero_q;
	logic [REM_W-1:0]         rem_q, dsor_q;
	logic [QUO_W-1:0]         quo_q;
	logic [3:0]               k_q;
	logic signed [NORM_W-1:0] n_q [3];
	logic                     done_q;

	logic                     big;
	logic [SQ_W-1:0]          sq_try, root_nx;
	logic                     sq_ge, div_ge, digit_last, comp_last;
	logic [QUO_W-1:0]         quo_nx;

	always_comb begin
		big     = |(m_q[0][MAG_W-1:RED_W] | m_q[1][MAG_W-1:RED_W] | m_q[2][MAG_W-1:RED_W]);
		sq_try  = root_q + bit_q;
		sq_ge   = sq_q >= sq_try;
		root_nx = sq_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
		div_ge  = rem_q >= dsor_q;
		quo_nx  = {quo_q[QUO_W-2:0], div_ge};
	end

	always_comb begin
		digit_last = (k_q == 4'd0);
		comp_last  = (cnt_q == 2'd2);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			NS_IDLE:  if (start) state_d = NS_SHIFT;
			NS_SHIFT: if (!big) state_d = NS_SQ;
			NS_SQ:    if (cnt_q == 2'd3) state_d = NS_SQRT;
			NS_SQRT:  if (bit_q[0]) state_d = NS_DIV;
			NS_DIV:   if (digit_last && comp_last) state_d = NS_IDLE;
			default:  state_d = NS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == NS_DIV) && digit_last && comp_last;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			NS_IDLE: begin
				if (start) begin
					neg_q[0] <= vec.x[CROSS_W-1];
					neg_q[1] <= vec.y[CROSS_W-1];
					neg_q[2] <= vec.z[CROSS_W-1];
					m_q[0]   <= vec.x[CROSS_W-1] ? MAG_W'(-vec.x) : MAG_W'(vec.x);
					m_q[1]   <= vec.y[CROSS_W-1] ? MAG_W'(-vec.y) : MAG_W'(vec.y);
					m_q[2]   <= vec.z[CROSS_W-1] ? MAG_W'(-vec.z) : MAG_W'(vec.z);
				end
			end
			NS_SHIFT: begin
				if (big) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else begin
					cnt_q <= 2'd0;
					sq_q  <= '0;
				end
			end
			NS_SQ: begin
				// Squares are registered and summed in the next cycle.
				if (cnt_q != 2'd3)
					prod_q <= m_q[cnt_q][RED_W-1:0] * m_q[cnt_q][RED_W-1:0];
				if (cnt_q != 2'd0)
					sq_q <= sq_q + SQ_W'(prod_q);
				cnt_q  <= cnt_q + 2'd1;
				root_q <= '0;
				bit_q  <= SQ_W'(1) << (SQ_W - 2);
			end
			NS_SQRT: begin
				if (sq_ge) sq_q <= sq_q - sq_try;
				root_q <= root_nx;
				bit_q  <= bit_q >> 2;
				if (bit_q[0]) begin
					len_q      <= root_nx[LEN_W-1:0];
					len_zero_q <= (root_nx == '0);
					dsor_q     <= REM_W'(root_nx[LEN_W-1:0]) << FRAC_W;
					rem_q      <= REM_W'(m_q[0][RED_W-1:0]) << FRAC_W;
					cnt_q      <= 2'd0;
					k_q        <= 4'(FRAC_W);
					quo_q      <= '0;
				end
			end
			NS_DIV: begin
				if (digit_last && !comp_last) begin
					cnt_q  <= cnt_q + 2'd1;
					rem_q  <= REM_W'(m_q[cnt_q + 2'd1][RED_W-1:0]) << FRAC_W;
					dsor_q <= REM_W'(len_q) << FRAC_W;
					k_q    <= 4'(FRAC_W);
					quo_q  <= '0;
				end else begin
					if (div_ge) rem_q <= rem_q - dsor_q;
					dsor_q <= dsor_q >> 1;
					quo_q  <= quo_nx;
					k_q    <= k_q - 4'd1;
				end
				if (digit_last) begin
					if (len_zero_q)
						n_q[cnt_q] <= '0;
					else if (neg_q[cnt_q])
						n_q[cnt_q] <= -NORM_W'(quo_nx);
					else
						n_q[cnt_q] <= NORM_W'(quo_nx);
				end
			end
			default: begin
			end
		endcase
	end

	assign done  = done_q;
	assign nrm.x = n_q[0];
	assign nrm.y = n_q[1];
	assign nrm.z = n_q[2];

endmodule

@@ design/mesh_vertex_normal_accumulator.sv @@
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator
// Vertex store and per-vertex normal sums built from unit face normals.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Each command
// gives exactly one result beat: done is high for one cycle with result valid,
// and the receiver takes it in that cycle; nothing can hold it off.
// Load, clear and any command with a bad index answer one cycle after the
// beat. A triangle reads its three corners, forms the cross product with one
// 25x25 multiplier, normalizes it and does three read-modify-writes of the
// sum memory. A read takes one memory read plus the normalizer, but skips
// the normalizer when the vertex was never used. The normalizer does up to
// 19 range shifts on a cross product, squares the components, then takes 31
// root steps and 45 divide steps.
// One command is in work at a time; busy is high while a valid triangle or
// read is in work, and while the sum memory is swept.
// After reset, and after each clear command, the block sweeps the sum memory
// to zero, one entry a cycle, over all VERTEX_DEPTH entries with busy high.
// Coordinates are kept in a second memory that is never cleared.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_accumulator import mvna_pkg::*; #(
	parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int AW  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int CW  = $clog2(VERTEX_DEPTH + 1);
	localparam int IXW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam logic signed [COORD_W:0] SUM_MAX = (COORD_W + 1)'(2 ** (COORD_W - 1) - 1);
	localparam logic signed [COORD_W:0] SUM_MIN = -(COORD_W + 1)'(2 ** (COORD_W - 1));

	function automatic logic [AW-1:0] to_addr(input logic [INDEX_W-1:0] c);
		logic [IXW-1:0] w;
		w = IXW'(c);
		return w[AW-1:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_add(
		input logic signed [COORD_W-1:0] s,
		input logic signed [NORM_W-1:0]  n
	);
		logic signed [COORD_W:0] t;
		t = (COORD_W + 1)'(s) + (COORD_W + 1)'(n);
		if (t > SUM_MAX) t = SUM_MAX;
		if (t < SUM_MIN) t = SUM_MIN;
		return t[COORD_W-1:0];
	endfunction

	state_t state_q, state_d;

	vec_t     store_mem [VERTEX_DEPTH];
	sum_ent_t sum_mem   [VERTEX_DEPTH];

	logic [CW-1:0]  count_q;
	logic [AW-1:0]  sweep_q;
	cmd_t           cmd_q;
	vec_t           va_q, vb_q, store_rd;
	sum_ent_t       sum_rd;
	logic signed [EDGE_W-1:0]  e1_q [3];
	logic signed [EDGE_W-1:0]  e2_q [3];
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CROSS_W-1:0] cr_q [3];
	logic [2:0]     step_q;
	logic [1:0]     acc_idx_q;
	nrm_t           fn_q;
	logic           done_q;
	result_t        result_q;

	logic           accept;
	logic           tri_ok, rd_ok, full;
	logic [1:0]     beat_status;
	logic           done_d;
	logic           store_we, sum_we;
	logic [AW-1:0]  store_wa, store_ra, sum_wa, sum_ra, acc_addr;
	vec_t           store_wd;
	sum_ent_t       sum_wd;
	logic           norm_start, norm_done;
	cross_t         norm_vec;
	nrm_t           norm_nrm;
	logic signed [EDGE_W-1:0] mul_a, mul_b;
	logic [1:0]     sel_a, sel_b;
	logic [1:0]     cr_idx;

	mvna_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vec    (norm_vec),
		.done   (norm_done),
		.nrm    (norm_nrm)
	);

	always_comb begin
		accept = start && (state_q == ST_IDLE);
		full   = (count_q == CW'(VERTEX_DEPTH));
		tri_ok = (IXW'(cmd.corner_a) < IXW'(count_q)) &&
			(IXW'(cmd.corner_b) < IXW'(count_q)) &&
			(IXW'(cmd.corner_c) < IXW'(count_q));
		rd_ok  = IXW'(cmd.corner_a) < IXW'(count_q);
		case (cmd.operation)
			OP_LOAD:     beat_status = full ? STATUS_FULL : STATUS_OK;
			OP_TRIANGLE: beat_status = tri_ok ? STATUS_OK : STATUS_BAD_INDEX;
			OP_READ:     beat_status = rd_ok ? STATUS_OK : STATUS_BAD_INDEX;
			default:     beat_status = STATUS_OK;
		endcase
		case (acc_idx_q)
			2'd0:    acc_addr = to_addr(cmd_q.corner_a);
			2'd1:    acc_addr = to_addr(cmd_q.corner_b);
			default: acc_addr = to_addr(cmd_q.corner_c);
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP:  if (sweep_q == AW'(VERTEX_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (cmd.operation)
						OP_TRIANGLE: if (tri_ok) state_d = ST_VRD_A;
						OP_READ:     if (rd_ok) state_d = ST_RD_SUM;
						OP_CLEAR:    state_d = ST_SWEEP;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_VRD_A:  state_d = ST_VRD_B;
			ST_VRD_B:  state_d = ST_VRD_C;
			ST_VRD_C:  state_d = ST_EDGE;
			ST_EDGE:   state_d = ST_MUL;
			ST_MUL:    if (step_q == 3'd7) state_d = ST_TNORM;
			ST_TNORM:  if (norm_done) state_d = ST_ACC_RD;
			ST_ACC_RD: state_d = ST_ACC_WR;
			ST_ACC_WR: state_d = (acc_idx_q == 2'd2) ? ST_IDLE : ST_ACC_RD;
			ST_RD_SUM: state_d = ST_RD_CHK;
			ST_RD_CHK: state_d = sum_rd.used ? ST_RNORM : ST_IDLE;
			ST_RNORM:  if (norm_done) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// A result beat follows every command that ends in this cycle.
	always_comb begin
		done_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.operation)
						OP_TRIANGLE: done_d = !tri_ok;
						OP_READ:     done_d = !rd_ok;
						default:     done_d = 1'b1;
					endcase
				end
			end
			ST_ACC_WR: done_d = (acc_idx_q == 2'd2);
			ST_RD_CHK: done_d = !sum_rd.used;
			ST_RNORM:  done_d = norm_done;
			default: begin
			end
		endcase
	end

	always_comb begin
		store_we   = accept && (cmd.operation == OP_LOAD) && !full;
		store_wa   = count_q[AW-1:0];
		store_wd.x = cmd.coord_x;
		store_wd.y = cmd.coord_y;
		store_wd.z = cmd.coord_z;
		case (state_q)
			ST_VRD_A: store_ra = to_addr(cmd_q.corner_a);
			ST_VRD_B: store_ra = to_addr(cmd_q.corner_b);
			default:  store_ra = to_addr(cmd_q.corner_c);
		endcase
		sum_we = 1'b0;
		sum_wa = sweep_q;
		sum_wd = '0;
		case (state_q)
			ST_SWEEP: sum_we = 1'b1;
			ST_ACC_WR: begin
				sum_we      = 1'b1;
				sum_wa      = acc_addr;
				sum_wd.used = 1'b1;
				sum_wd.x    = sat_add(sum_rd.x, fn_q.x);
				sum_wd.y    = sat_add(sum_rd.y, fn_q.y);
				sum_wd.z    = sat_add(sum_rd.z, fn_q.z);
			end
			default: begin
			end
		endcase
		sum_ra = (state_q == ST_RD_SUM) ? to_addr(cmd_q.corner_a) : acc_addr;
		norm_start = ((state_q == ST_MUL) && (step_q == 3'd7)) ||
			((state_q == ST_RD_CHK) && sum_rd.used);
		if (state_q == ST_RD_CHK) begin
			norm_vec.x = CROSS_W'(sum_rd.x);
			norm_vec.y = CROSS_W'(sum_rd.y);
			norm_vec.z = CROSS_W'(sum_rd.z);
		end else begin
			norm_vec.x = cr_q[0];
			norm_vec.y = cr_q[1];
			norm_vec.z = cr_q[2];
		end
	end

	// Cross product terms in order: two products for each component, the
	// second one subtracted.
	always_comb begin
		case (step_q)
			3'd0:    begin sel_a = 2'd1; sel_b = 2'd2; end
			3'd1:    begin sel_a = 2'd2; sel_b = 2'd1; end
			3'd2:    begin sel_a = 2'd2; sel_b = 2'd0; end
			3'd3:    begin sel_a = 2'd0; sel_b = 2'd2; end
			3'd4:    begin sel_a = 2'd0; sel_b = 2'd1; end
			default: begin sel_a = 2'd1; sel_b = 2'd0; end
		endcase
		mul_a  = e1_q[sel_a];
		mul_b  = e2_q[sel_b];
		cr_idx = 2'((step_q - 3'd1) >> 1);
	end

	always_ff @(posedge clk) begin
		if (store_we) store_mem[store_wa] <= store_wd;
		store_rd <= store_mem[store_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_wa] <= sum_wd;
		sum_rd <= sum_mem[sum_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			sweep_q   <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
			step_q    <= '0;
			acc_idx_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			case (state_q)
				ST_SWEEP: sweep_q <= sweep_q + AW'(1);
				ST_IDLE: begin
					if (accept) begin
						case (cmd.operation)
							OP_LOAD: if (!full) count_q <= count_q + CW'(1);
							OP_CLEAR: begin
								count_q <= '0;
								sweep_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_EDGE: step_q <= '0;
				ST_MUL:  step_q <= step_q + 3'd1;
				ST_TNORM: acc_idx_q <= '0;
				ST_ACC_WR: acc_idx_q <= acc_idx_q + 2'd1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q                 <= cmd;
					result_q.status       <= beat_status;
					result_q.normal_x     <= '0;
					result_q.normal_y     <= '0;
					result_q.normal_z     <= '0;
					result_q.normal_valid <= 1'b0;
				end
			end
			ST_VRD_B: va_q <= store_rd;
			ST_VRD_C: vb_q <= store_rd;
			ST_EDGE: begin
				e1_q[0] <= EDGE_W'(vb_q.x) - EDGE_W'(va_q.x);
				e1_q[1] <= EDGE_W'(vb_q.y) - EDGE_W'(va_q.y);
				e1_q[2] <= EDGE_W'(vb_q.z) - EDGE_W'(va_q.z);
				e2_q[0] <= EDGE_W'(store_rd.x) - EDGE_W'(va_q.x);
				e2_q[1] <= EDGE_W'(store_rd.y) - EDGE_W'(va_q.y);
				e2_q[2] <= EDGE_W'(store_rd.z) - EDGE_W'(va_q.z);
			end
			ST_MUL: begin
				if (step_q != 3'd7) prod_q <= mul_a * mul_b;
				if ((step_q != 3'd0) && (step_q != 3'd7)) begin
					if (!step_q[0])
						cr_q[cr_idx] <= cr_q[cr_idx] - CROSS_W'(prod_q);
					else
						cr_q[cr_idx] <= CROSS_W'(prod_q);
				end
			end
			ST_TNORM: if (norm_done) fn_q <= norm_nrm;
			ST_RNORM: begin
				if (norm_done) begin
					result_q.normal_x     <= norm_nrm.x;
					result_q.normal_y     <= norm_nrm.y;
					result_q.normal_z     <= norm_nrm.z;
					result_q.normal_valid <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ bench/mesh_vertex_normal_accumulator_test.sv @@
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator_test
// Self-checking bench for the vertex normal accumulator. Command beats are
// driven through start/busy with random gaps, a local model of the vertex
// store and normal sums predicts every result, and each result beat taken on
// done is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_accumulator_test;
	import mvna_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = VERTEX_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SUM_HI      = 8388607;
	localparam int SUM_LO      = -8388608;

	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    done;
	result_t result;

	mesh_vertex_normal_accumulator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Local copy of the block's state.
	int          mesh_count;
	longint      pos_x [DEPTH];
	longint      pos_y [DEPTH];
	longint      pos_z [DEPTH];
	longint      acc_x [DEPTH];
	longint      acc_y [DEPTH];
	longint      acc_z [DEPTH];
	bit          touched [DEPTH];

	result_t     pending_results[$];
	int          failures;
	int          beats_sent;
	int          beats_checked;
	int          op_hits [4];
	int          status_hits [3];
	int          valid_reads;
	bit          no_gaps;
	longint      cycles;

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic nrm_t unit_vector(longint cx, longint cy, longint cz);
		longint          c [3];
		longint unsigned m [3];
		longint unsigned big, sq, len, q;
		bit              neg [3];
		logic signed [NORM_W-1:0] n [3];
		nrm_t            v;
		int              s;
		c[0] = cx;
		c[1] = cy;
		c[2] = cz;
		big = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i] < 0;
			m[i] = neg[i] ? -c[i] : c[i];
			if (m[i] > big)
				big = m[i];
		end
		s = 0;
		while ((big >> s) >= (64'd1 << 30))
			s++;
		for (int i = 0; i < 3; i++) begin
			m[i] >>= s;
			sq += m[i] * m[i];
		end
		len = root_floor(sq);
		for (int i = 0; i < 3; i++) begin
			q = (len == 0) ? 0 : (m[i] * 16384) / len;
			n[i] = neg[i] ? -q[NORM_W-1:0] : q[NORM_W-1:0];
		end
		v.x = n[0];
		v.y = n[1];
		v.z = n[2];
		return v;
	endfunction

	function automatic longint clamp_sum(longint a);
		if (a > SUM_HI)
			return SUM_HI;
		if (a < SUM_LO)
			return SUM_LO;
		return a;
	endfunction

	function automatic void clear_mesh_state();
		mesh_count = 0;
		for (int i = 0; i < DEPTH; i++) begin
			acc_x[i] = 0;
			acc_y[i] = 0;
			acc_z[i] = 0;
			touched[i] = 0;
		end
	endfunction

	// Applies one command to the local state and gives the result it causes.
	function automatic result_t apply_command(cmd_t c);
		result_t r;
		longint  e1x, e1y, e1z, e2x, e2y, e2z;
		nrm_t    fn;
		int      idx [3];
		r = '0;
		r.status = STATUS_OK;
		case (c.operation)
			OP_LOAD: begin
				if (mesh_count >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					pos_x[mesh_count] = c.coord_x;
					pos_y[mesh_count] = c.coord_y;
					pos_z[mesh_count] = c.coord_z;
					mesh_count++;
				end
			end
			OP_TRIANGLE: begin
				idx[0] = c.corner_a;
				idx[1] = c.corner_b;
				idx[2] = c.corner_c;
				if (idx[0] >= mesh_count || idx[1] >= mesh_count || idx[2] >= mesh_count) begin
					r.status = STATUS_BAD_INDEX;
				end else begin
					e1x = pos_x[idx[1]] - pos_x[idx[0]];
					e1y = pos_y[idx[1]] - pos_y[idx[0]];
					e1z = pos_z[idx[1]] - pos_z[idx[0]];
					e2x = pos_x[idx[2]] - pos_x[idx[0]];
					e2y = pos_y[idx[2]] - pos_y[idx[0]];
					e2z = pos_z[idx[2]] - pos_z[idx[0]];
					fn = unit_vector(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
						e1x * e2y - e1y * e2x);
					// A corner named twice collects the face normal twice.
					for (int i = 0; i < 3; i++) begin
						acc_x[idx[i]] = clamp_sum(acc_x[idx[i]] + fn.x);
						acc_y[idx[i]] = clamp_sum(acc_y[idx[i]] + fn.y);
						acc_z[idx[i]] = clamp_sum(acc_z[idx[i]] + fn.z);
						touched[idx[i]] = 1;
					end
				end
			end
			OP_READ: begin
				if (c.corner_a >= mesh_count) begin
					r.status = STATUS_BAD_INDEX;
				end else if (touched[c.corner_a]) begin
					fn = unit_vector(acc_x[c.corner_a], acc_y[c.corner_a], acc_z[c.corner_a]);
					r.normal_x = fn.x;
					r.normal_y = fn.y;
					r.normal_z = fn.z;
					r.normal_valid = 1'b1;
				end
			end
			default: begin
				clear_mesh_state();
			end
		endcase
		return r;
	endfunction

	// Sends one command beat; inputs move only on the falling edge.
	task automatic send_command(cmd_t c);
		result_t r;
		if (!no_gaps && $urandom_range(0, 99) < 28) begin
			@(negedge clk);
			start = 1'b0;
			cmd = cmd_t'({$urandom, $urandom, $urandom});
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		do
			@(posedge clk);
		while (busy);
		r = apply_command(c);
		if (r.normal_valid)
			valid_reads++;
		op_hits[c.operation]++;
		status_hits[r.status]++;
		pending_results.push_back(r);
		beats_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic cmd_t make_cmd(logic [1:0] op, int a, int b, int c);
		cmd_t k;
		k = cmd_t'({$urandom, $urandom, $urandom});
		k.operation = op;
		k.corner_a = INDEX_W'(a);
		k.corner_b = INDEX_W'(b);
		k.corner_c = INDEX_W'(c);
		return k;
	endfunction

	function automatic cmd_t make_vertex(int x, int y, int z);
		cmd_t k;
		k = make_cmd(OP_LOAD, $urandom, $urandom, $urandom);
		k.coord_x = COORD_W'(x);
		k.coord_y = COORD_W'(y);
		k.coord_z = COORD_W'(z);
		return k;
	endfunction

	function automatic cmd_t random_vertex();
		cmd_t k;
		k = make_cmd(OP_LOAD, $urandom, $urandom, $urandom);
		if ($urandom_range(0, 3) != 0) begin
			k.coord_x = COORD_W'($signed($urandom_range(0, 8191)) - 4096);
			k.coord_y = COORD_W'($signed($urandom_range(0, 8191)) - 4096);
			k.coord_z = COORD_W'($signed($urandom_range(0, 8191)) - 4096);
			k.coord_x = k.coord_x <<< $urandom_range(0, 11);
		end
		return k;
	endfunction

	// Result check: every done beat is matched with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no prediction waiting");
				failures++;
			end else begin
				want = pending_results.pop_front();
				beats_checked++;
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					failures++;
				end
				if (result.normal_x !== want.normal_x) begin
					$error("normal_x: expected %0d, got %0d", want.normal_x, result.normal_x);
					failures++;
				end
				if (result.normal_y !== want.normal_y) begin
					$error("normal_y: expected %0d, got %0d", want.normal_y, result.normal_y);
					failures++;
				end
				if (result.normal_z !== want.normal_z) begin
					$error("normal_z: expected %0d, got %0d", want.normal_z, result.normal_z);
					failures++;
				end
				if (result.normal_valid !== want.normal_valid) begin
					$error("normal_valid: expected %0d, got %0d", want.normal_valid,
						result.normal_valid);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed_ops();
		send_command(make_cmd(OP_READ, 0, 0, 0));
		send_command(make_cmd(OP_TRIANGLE, 0, 0, 0));
		send_command(make_vertex(SUM_LO, SUM_HI, 0));
		send_command(make_vertex(SUM_HI, SUM_LO, SUM_HI));
		send_command(make_vertex(0, 0, SUM_LO));
		send_command(make_vertex(65536, 0, 0));
		send_command(make_vertex(0, 65536, 0));
		send_command(make_vertex(0, 0, 0));
		send_command(make_cmd(OP_READ, 1, 0, 0));
		send_command(make_cmd(OP_TRIANGLE, 0, 1, 2));
		send_command(make_cmd(OP_TRIANGLE, 5, 3, 4));
		send_command(make_cmd(OP_TRIANGLE, 5, 5, 3));
		send_command(make_cmd(OP_TRIANGLE, 2, 2, 2));
		send_command(make_cmd(OP_TRIANGLE, 0, 1, 1023));
		send_command(make_cmd(OP_TRIANGLE, 6, 0, 1));
		send_command(make_cmd(OP_READ, 0, 0, 0));
		send_command(make_cmd(OP_READ, 2, 0, 0));
		send_command(make_cmd(OP_READ, 5, 0, 0));
		send_command(make_cmd(OP_READ, 3, 0, 0));
		send_command(make_cmd(OP_READ, 1023, 0, 0));
		send_command(make_cmd(OP_CLEAR, 0, 0, 0));
		send_command(make_cmd(OP_READ, 0, 0, 0));
		wait_for_results();
	endtask

	// Hundreds of identical faces drive the sums of their corners into the upper rail.
	task automatic test_sum_saturation();
		send_command(make_vertex(0, 0, 0));
		send_command(make_vertex(0, 65536, 0));
		send_command(make_vertex(0, 0, 65536));
		send_command(make_vertex(0, 0, 0));
		send_command(make_vertex(0, 0, 65536));
		send_command(make_vertex(0, 65536, 0));
		for (int i = 0; i < 520; i++)
			send_command(make_cmd(OP_TRIANGLE, 0, 1, 2));
		send_command(make_cmd(OP_READ, 0, 0, 0));
		send_command(make_cmd(OP_READ, 3, 0, 0));
		send_command(make_cmd(OP_CLEAR, 0, 0, 0));
		wait_for_results();
	endtask

	task automatic test_store_full();
		no_gaps = 1;
		for (int i = 0; i < DEPTH; i++)
			send_command(random_vertex());
		no_gaps = 0;
		send_command(random_vertex());
		send_command(make_cmd(OP_TRIANGLE, 1021, 1022, 1023));
		send_command(make_cmd(OP_TRIANGLE, 1023, 0, 511));
		send_command(make_cmd(OP_READ, 1023, 0, 0));
		send_command(make_cmd(OP_READ, 512, 0, 0));
		send_command(make_cmd(OP_CLEAR, 0, 0, 0));
		wait_for_results();
	endtask

	task automatic test_random_meshes(int quota);
		int first, ops, pick, n;
		first = beats_sent;
		while (beats_sent - first < quota) begin
			no_gaps = ($urandom_range(0, 5) == 0);
			if (mesh_count > 900 || $urandom_range(0, 3) == 0)
				send_command(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom));
			repeat ($urandom_range(3, 40))
				send_command(random_vertex());
			ops = $urandom_range(10, 40);
			repeat (ops) begin
				pick = $urandom_range(0, 99);
				n = mesh_count;
				if (pick < 55)
					send_command(make_cmd(OP_TRIANGLE, $urandom_range(0, n - 1),
						$urandom_range(0, n - 1), $urandom_range(0, n - 1)));
				else if (pick < 80)
					send_command(make_cmd(OP_READ, $urandom_range(0, n - 1), $urandom, 0));
				else if (pick < 88)
					send_command(make_cmd(OP_TRIANGLE, $urandom_range(0, n - 1),
						$urandom_range(n, 1023), $urandom_range(0, 1023)));
				else if (pick < 93)
					send_command(make_cmd(OP_READ, $urandom_range(n, 1023), $urandom, 0));
				else
					send_command(random_vertex());
			end
			if ($urandom_range(0, 9) == 0)
				wait_for_results();
		end
		no_gaps = 0;
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		failures = 0;
		beats_sent = 0;
		beats_checked = 0;
		valid_reads = 0;
		no_gaps = 0;
		cycles = 0;
		op_hits = '{default: 0};
		status_hits = '{default: 0};
		clear_mesh_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_sum_saturation();
		test_store_full();
		test_random_meshes(150);

		repeat (200) @(posedge clk);
		$display("%0d command beats (load %0d, triangle %0d, read %0d, clear %0d), %0d checked",
			beats_sent, op_hits[OP_LOAD], op_hits[OP_TRIANGLE], op_hits[OP_READ],
			op_hits[OP_CLEAR], beats_checked);
		$display("status ok %0d, bad index %0d, store full %0d; %0d reads gave a normal",
			status_hits[STATUS_OK], status_hits[STATUS_BAD_INDEX], status_hits[STATUS_FULL],
			valid_reads);
		if (failures == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
